FILE: hdl/bsmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_pkg
// Shared types and constants for the backing store map table.
// ----------------------------------------------------------------------------
package bsmt_pkg;

    // Default sizing, handed to the top level parameters
    localparam int STORE_COUNT_DEF = 8;
    localparam int PROC_COUNT_DEF  = 64;
    localparam int PAGE_SHIFT_DEF  = 12;

    // Fixed field widths
    localparam int PAGE_W   = 20;
    localparam int COUNT_W  = 9;
    localparam int OFFSET_W = 8;

    // Allocate only scans stores the 3-bit store field can name
    localparam int FIELD_STORES = 8;

    // Page count saturation limit
    localparam logic [COUNT_W-1:0] MAX_PAGES = 9'd256;

    // Request codes
    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_MAP    = 2'd2,
        ACT_LOOKUP = 2'd3
    } t_action;

    // Response codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_NO_MAP  = 2'd2
    } t_status;

    // One table entry: use mark, base page, page count
    typedef struct packed {
        logic               used;
        logic [PAGE_W-1:0]  base;
        logic [COUNT_W-1:0] count;
    } t_slot;

    // Range check outcome
    typedef struct packed {
        logic                hit;
        logic [OFFSET_W-1:0] offset;
    } t_match;

endpackage

FILE: hdl/bsmt_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_slot_mem
// Per-store, per-process entry memory: one write port, one registered read.
// ----------------------------------------------------------------------------
module bsmt_slot_mem
    import bsmt_pkg::*;
#(
    parameter int AW = 9
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [2**AW];
    t_slot r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/bsmt_range_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_range_cmp
// Shared range check: base <= page < base + count, with page offset.
// ----------------------------------------------------------------------------
module bsmt_range_cmp
    import bsmt_pkg::*;
(
    input  t_slot             i_slot,
    input  logic [PAGE_W-1:0] i_page,
    output t_match            o_match
);

    logic [PAGE_W:0]   w_hi;
    logic [PAGE_W-1:0] w_diff;

    // Upper bound computed one bit wider, so no wrap
    assign w_hi   = {1'b0, i_slot.base} + {{(PAGE_W + 1 - COUNT_W){1'b0}}, i_slot.count};
    assign w_diff = i_page - i_slot.base;

    assign o_match.hit    = i_slot.used && (i_page >= i_slot.base) && ({1'b0, i_page} < w_hi);
    assign o_match.offset = w_diff[OFFSET_W-1:0];

endmodule

FILE: hdl/backing_store_map_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backing_store_map_table
// Backing store allocator with per-process page range lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid / o_stall carries one transaction: action, process,
//   store, vpage, npages, vaddr. Response channel o_valid / i_stall returns
//   exactly one transaction per request: status, store_index, page_offset.
//   One request is worked on at a time; o_stall is high while it runs.
//   Steps from accept to response valid:
//     allocate : tests stores in turn (up to min(STORE_COUNT, 8))
//     free     : clears a row of 2**ceil(log2(PROC_COUNT)) entries (64 by default)
//     map      : writes one entry
//     lookup   : reads, then range checks, each store in turn up to STORE_COUNT
//   The table memory has a single read and a single write port; lookup
//   reads one store entry at a time through the shared range checker.
//   After reset the table memory is swept clear, one entry per cycle, over all
//   2**(store bits + process bits) entries (512 by default) with o_stall high.
//   The response sits in an output register; a new request is accepted
//   while it waits. If the receiver stalls and a second response is ready,
//   the block holds it and keeps o_stall high until the register drains.
// ----------------------------------------------------------------------------
module backing_store_map_table
    import bsmt_pkg::*;
#(
    parameter int STORE_COUNT = STORE_COUNT_DEF,
    parameter int PROC_COUNT  = PROC_COUNT_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_action,
    input  logic [5:0]          i_process,
    input  logic [2:0]          i_store,
    input  logic [PAGE_W-1:0]   i_vpage,
    input  logic [COUNT_W-1:0]  i_npages,
    input  logic [31:0]         i_vaddr,
    // response channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [2:0]          o_store_index,
    output logic [OFFSET_W-1:0] o_page_offset
);

    localparam int SW      = (STORE_COUNT > 1) ? $clog2(STORE_COUNT) : 1;
    localparam int PW      = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
    localparam int AW      = SW + PW;
    localparam int ALLOC_N = (STORE_COUNT < FIELD_STORES) ? STORE_COUNT : FIELD_STORES;

    localparam logic [SW-1:0] LAST_STORE = SW'(STORE_COUNT - 1);
    localparam logic [SW-1:0] LAST_ALLOC = SW'(ALLOC_N - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ALLOC = 8'b0000_0100,
        S_FREE  = 8'b0000_1000,
        S_MAP   = 8'b0001_0000,
        S_RDREQ = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_sweep;
    logic [SW-1:0]          r_k;
    logic [STORE_COUNT-1:0] r_mapped;

    // captured request
    logic [5:0]             r_proc;
    logic [2:0]             r_store;
    logic [PAGE_W-1:0]      r_vpage;
    logic [COUNT_W-1:0]     r_npages;
    logic [PAGE_W-1:0]      r_page;

    // pending result
    t_status                r_res_status;
    logic [2:0]             r_res_idx;
    logic [OFFSET_W-1:0]    r_res_off;

    // output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [2:0]             r_out_idx;
    logic [OFFSET_W-1:0]    r_out_off;

    logic                   w_accept;
    logic                   w_out_load;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    t_slot                  w_wr_data;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    t_slot                  w_rd_data;
    t_match                 w_match;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // Memory write: reset sweep, row clear on free, single entry on map
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = {SW'(r_store), PW'(r_proc)};
        w_wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_sweep;
            end
            S_FREE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = {SW'(r_store), r_sweep[PW-1:0]};
            end
            S_MAP: begin
                w_wr_en   = 1'b1;
                w_wr_data = '{used: 1'b1, base: r_vpage, count: r_npages};
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    // Lookup reads one store entry per visit
    assign w_rd_en   = (r_state == S_RDREQ);
    assign w_rd_addr = {r_k, PW'(r_proc)};

    bsmt_slot_mem #(
        .AW(AW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bsmt_range_cmp u_range_cmp (
        .i_slot  (w_rd_data),
        .i_page  (r_page),
        .o_match (w_match)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sweep  <= '0;
            r_k      <= '0;
            r_mapped <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (&r_sweep) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_proc       <= i_process;
                        r_store      <= i_store;
                        r_vpage      <= i_vpage;
                        r_npages     <= (i_npages > MAX_PAGES) ? MAX_PAGES : i_npages;
                        r_page       <= PAGE_W'(i_vaddr >> PAGE_SHIFT);
                        r_res_status <= STAT_OK;
                        r_res_idx    <= '0;
                        r_res_off    <= '0;
                        r_k          <= '0;
                        r_sweep      <= '0;
                        case (t_action'(i_action))
                            ACT_ALLOC: begin
                                r_state <= S_ALLOC;
                            end
                            ACT_FREE: begin
                                if (32'(i_store) < STORE_COUNT) begin
                                    r_mapped[SW'(i_store)] <= 1'b0;
                                    r_state                <= S_FREE;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            ACT_MAP: begin
                                if ((32'(i_store) < STORE_COUNT) &&
                                    (32'(i_process) < PROC_COUNT)) begin
                                    r_state <= S_MAP;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            ACT_LOOKUP: begin
                                if (32'(i_process) < PROC_COUNT) begin
                                    r_state <= S_RDREQ;
                                end else begin
                                    r_res_status <= STAT_NO_MAP;
                                    r_state      <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // first unmapped store, one store per cycle
                S_ALLOC: begin
                    if (!r_mapped[r_k]) begin
                        r_mapped[r_k] <= 1'b1;
                        r_res_idx     <= 3'(r_k);
                        r_state       <= S_DONE;
                    end else if (r_k == LAST_ALLOC) begin
                        r_res_status <= STAT_NO_FREE;
                        r_state      <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                // clear every process entry of the freed store
                S_FREE: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (&r_sweep[PW-1:0]) begin
                        r_state <= S_DONE;
                    end
                end
                S_MAP: begin
                    r_state <= S_DONE;
                end
                S_RDREQ: begin
                    r_state <= S_CHECK;
                end
                // range check on the entry just read
                S_CHECK: begin
                    if (w_match.hit) begin
                        r_res_idx <= 3'(r_k);
                        r_res_off <= w_match.offset;
                        r_state   <= S_DONE;
                    end else if (r_k == LAST_STORE) begin
                        r_res_status <= STAT_NO_MAP;
                        r_state      <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RDREQ;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
            r_out_off    <= r_res_off;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_store_index = r_out_idx;
    assign o_page_offset = r_out_off;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("request accepted but block not busy next cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_NO_FREE ||
                     o_status == STAT_NO_MAP))
        else $error("undefined response status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_OK) |-> (o_store_index == '0 && o_page_offset == '0))
        else $error("failed response carries nonzero index or offset");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("table written outside a working state");

endmodule

FILE: tb/bsmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmt_checker
// Watches both channels of the backing store map table. Every request
// transaction is run through a local copy of the table to work out its reply.
// Every reply transaction is compared field by field with the oldest reply
// still due. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module bsmt_checker
    import bsmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  logic [1:0]          i_action,
    input  logic [5:0]          i_process,
    input  logic [2:0]          i_store,
    input  logic [PAGE_W-1:0]   i_vpage,
    input  logic [COUNT_W-1:0]  i_npages,
    input  logic [31:0]         i_vaddr,
    // reply channel
    input  logic                i_rsp_valid,
    input  logic                i_rsp_stall,
    input  logic [1:0]          i_status,
    input  logic [2:0]          i_store_index,
    input  logic [OFFSET_W-1:0] i_page_offset,
    // to the top
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        t_status             status;
        logic [2:0]          index;
        logic [OFFSET_W-1:0] offset;
    } t_reply;

    // Local copy of the table
    logic               store_busy [STORE_COUNT_DEF];
    logic               use_mark   [STORE_COUNT_DEF][PROC_COUNT_DEF];
    logic [PAGE_W-1:0]  base_pg    [STORE_COUNT_DEF][PROC_COUNT_DEF];
    logic [COUNT_W-1:0] span_pg    [STORE_COUNT_DEF][PROC_COUNT_DEF];

    t_reply replies_due[$];

    // Apply one request to the local table and return the reply it earns
    function automatic t_reply table_answer(
        input t_action            act,
        input logic [5:0]         proc,
        input logic [2:0]         st,
        input logic [PAGE_W-1:0]  vp,
        input logic [COUNT_W-1:0] np,
        input logic [31:0]        va
    );
        t_reply            r;
        logic              found;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W:0]   limit;
        r        = '0;
        r.status = STAT_OK;
        found    = 1'b0;
        case (act)
            ACT_ALLOC: begin
                // lowest unmapped store among those the store field can name
                r.status = STAT_NO_FREE;
                for (int k = 0; k < STORE_COUNT_DEF && k < FIELD_STORES; k++) begin
                    if (!found && !store_busy[k]) begin
                        store_busy[k] = 1'b1;
                        r.status      = STAT_OK;
                        r.index       = 3'(k);
                        found         = 1'b1;
                    end
                end
            end
            ACT_FREE: begin
                if (st < STORE_COUNT_DEF) begin
                    store_busy[st] = 1'b0;
                    for (int p = 0; p < PROC_COUNT_DEF; p++)
                        use_mark[st][p] = 1'b0;
                end
            end
            ACT_MAP: begin
                // mapped flag is left alone; count saturates
                if (st < STORE_COUNT_DEF && proc < PROC_COUNT_DEF) begin
                    use_mark[st][proc] = 1'b1;
                    base_pg[st][proc]  = vp;
                    span_pg[st][proc]  = (np > MAX_PAGES) ? MAX_PAGES : np;
                end
            end
            ACT_LOOKUP: begin
                // first marked range that covers the page, no wrap at the top
                page     = PAGE_W'(va >> PAGE_SHIFT_DEF);
                r.status = STAT_NO_MAP;
                if (proc < PROC_COUNT_DEF) begin
                    for (int k = 0; k < STORE_COUNT_DEF; k++) begin
                        limit = {1'b0, base_pg[k][proc]} + (PAGE_W+1)'(span_pg[k][proc]);
                        if (!found && use_mark[k][proc] && page >= base_pg[k][proc]
                            && {1'b0, page} < limit) begin
                            r.status = STAT_OK;
                            r.index  = 3'(k);
                            r.offset = OFFSET_W'(page - base_pg[k][proc]);
                            found    = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Replies are retired before requests are added; a request never
    // answers in the cycle it is taken
    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_COUNT_DEF; k++) begin
                store_busy[k] = 1'b0;
                for (int p = 0; p < PROC_COUNT_DEF; p++) begin
                    use_mark[k][p] = 1'b0;
                    base_pg[k][p]  = '0;
                    span_pg[k][p]  = '0;
                end
            end
            replies_due.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got.status = t_status'(i_status);
                got.index  = i_store_index;
                got.offset = i_page_offset;
                if (replies_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: reply with none outstanding: status %0d index %0d offset %0d",
                                 $time, got.status, got.index, got.offset);
                    o_errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status || got.index !== want.index
                        || got.offset !== want.offset) begin
                        if (o_errors < 10)
                            $display("%0t: reply mismatch: expected status %0d index %0d offset %0d, got status %0d index %0d offset %0d",
                                     $time, want.status, want.index, want.offset,
                                     got.status, got.index, got.offset);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                replies_due.push_back(table_answer(t_action'(i_action), i_process, i_store,
                                                   i_vpage, i_npages, i_vaddr));
            o_pending = replies_due.size();
        end
    end

endmodule

FILE: tb/tb_backing_store_map_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backing_store_map_table
// Drives allocate, free, map and lookup requests into the backing store map
// table: a directed opening on the corner cases, then three random phases with
// sender idling, receiver stalls, both swapped, and none. A checker beside the
// block predicts and compares every reply; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_backing_store_map_table;
    import bsmt_pkg::*;

    localparam int PHASE_ITEMS = 300;
    localparam int HANG_LIMIT  = 5000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_valid       = 1'b0;
    logic                o_stall;
    logic [1:0]          i_action      = '0;
    logic [5:0]          i_process     = '0;
    logic [2:0]          i_store       = '0;
    logic [PAGE_W-1:0]   i_vpage       = '0;
    logic [COUNT_W-1:0]  i_npages      = '0;
    logic [31:0]         i_vaddr       = '0;
    logic                o_valid;
    logic                i_stall       = 1'b0;
    logic [1:0]          o_status;
    logic [2:0]          o_store_index;
    logic [OFFSET_W-1:0] o_page_offset;

    int fail_count;
    int replies_pending;
    int send_idle_pct = 31;
    int stall_pct     = 68;
    int hang_cycles   = 0;

    // What the last map of each store looked like, to aim lookups at it
    logic               aim_live [FIELD_STORES] = '{default: 1'b0};
    logic [5:0]         aim_proc [FIELD_STORES];
    logic [PAGE_W-1:0]  aim_base [FIELD_STORES];
    logic [COUNT_W-1:0] aim_cnt  [FIELD_STORES];

    backing_store_map_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_process     (i_process),
        .i_store       (i_store),
        .i_vpage       (i_vpage),
        .i_npages      (i_npages),
        .i_vaddr       (i_vaddr),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_store_index (o_store_index),
        .o_page_offset (o_page_offset)
    );

    bsmt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_action      (i_action),
        .i_process     (i_process),
        .i_store       (i_store),
        .i_vpage       (i_vpage),
        .i_npages      (i_npages),
        .i_vaddr       (i_vaddr),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_status      (o_status),
        .i_store_index (o_store_index),
        .i_page_offset (o_page_offset),
        .o_errors      (fail_count),
        .o_pending     (replies_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver stalls at random
    always @(posedge i_clk)
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Hang detection: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One request transaction; returns at the edge that takes it
    task automatic send_request(
        input t_action            act,
        input logic [5:0]         proc,
        input logic [2:0]         st,
        input logic [PAGE_W-1:0]  vp,
        input logic [COUNT_W-1:0] np,
        input logic [31:0]        va
    );
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_process <= proc;
        i_store   <= st;
        i_vpage   <= vp;
        i_npages  <= np;
        i_vaddr   <= va;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end
        if (act == ACT_MAP) begin
            aim_live[st] = 1'b1;
            aim_proc[st] = proc;
            aim_base[st] = vp;
            aim_cnt[st]  = np;
        end else if (act == ACT_FREE) begin
            aim_live[st] = 1'b0;
        end
    endtask

    // Hold off the sender until every reply is back, then switch idling and stall rates
    task automatic drain_replies(input int next_send, input int next_stall);
        i_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (replies_pending != 0);
        send_idle_pct = next_send;
        stall_pct     = next_stall;
        @(posedge i_clk);
    endtask

    // Mostly maps over a narrow page window and lookups aimed at live ranges
    task automatic random_request();
        t_action            act;
        logic [5:0]         proc;
        logic [2:0]         st;
        logic [PAGE_W-1:0]  vp;
        logic [PAGE_W-1:0]  pg;
        logic [COUNT_W-1:0] np;
        logic [31:0]        va;
        int                 r;
        int                 k;
        int                 span;
        r    = $urandom_range(99);
        proc = ($urandom_range(9) < 8) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
        st   = 3'($urandom_range(7));
        vp   = PAGE_W'($urandom);
        np   = COUNT_W'($urandom_range(511));
        va   = $urandom;
        if (r < 14) begin
            act = ACT_ALLOC;
        end else if (r < 24) begin
            act = ACT_FREE;
        end else if (r < 55) begin
            act = ACT_MAP;
            r = $urandom_range(9);
            if (r < 7)
                vp = PAGE_W'($urandom_range(2047));
            else if (r < 8)
                vp = 20'hFFFFF - PAGE_W'($urandom_range(300));
            r = $urandom_range(9);
            if (r < 8)
                np = COUNT_W'($urandom_range(256, 1));
            else if (r < 9)
                np = '0;
            else
                np = COUNT_W'($urandom_range(511, 257));
        end else begin
            act = ACT_LOOKUP;
            k = $urandom_range(FIELD_STORES - 1);
            if (aim_live[k] && $urandom_range(9) < 8) begin
                proc = aim_proc[k];
                span = (aim_cnt[k] > MAX_PAGES) ? int'(MAX_PAGES) : int'(aim_cnt[k]);
                // one past either end now and then
                if ($urandom_range(19) == 0)
                    pg = aim_base[k] - 1'b1;
                else
                    pg = aim_base[k] + PAGE_W'($urandom_range(span));
                va = {pg, va[11:0]};
            end
        end
        send_request(act, proc, st, vp, np, va);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every store, then one more
        repeat (9) send_request(ACT_ALLOC, '0, '0, '0, '0, '0);
        send_request(ACT_FREE, '0, 3'd3, '0, '0, '0);
        send_request(ACT_ALLOC, '0, '0, '0, '0, '0);
        // range extremes: full count at zero, saturated count at the top page, empty range
        send_request(ACT_MAP, 6'd0, 3'd0, 20'h00000, 9'd256, '0);
        send_request(ACT_MAP, 6'd63, 3'd7, 20'hFFFFF, 9'd511, '0);
        send_request(ACT_MAP, 6'd5, 3'd5, 20'h004D2, 9'd0, '0);
        send_request(ACT_LOOKUP, 6'd0, '0, '0, '0, 32'h0000_0000);
        send_request(ACT_LOOKUP, 6'd0, '0, '0, '0, 32'h000F_FFFF);
        send_request(ACT_LOOKUP, 6'd0, '0, '0, '0, 32'h0010_0000);
        send_request(ACT_LOOKUP, 6'd63, '0, '0, '0, 32'hFFFF_FFFF);
        send_request(ACT_LOOKUP, 6'd5, '0, '0, '0, 32'h004D_2000);
        // a freed store must not match any more
        send_request(ACT_FREE, '0, 3'd0, '0, '0, '0);
        send_request(ACT_LOOKUP, 6'd0, '0, '0, '0, 32'h0000_0000);
        // map into an unmapped store still records the range
        send_request(ACT_MAP, 6'd1, 3'd0, 20'h00010, 9'd4, '0);
        send_request(ACT_LOOKUP, 6'd1, '0, '0, '0, 32'h0001_3ABC);
        send_request(ACT_ALLOC, '0, '0, '0, '0, '0);
        drain_replies(31, 68);

        repeat (PHASE_ITEMS) random_request();
        drain_replies(68, 31);
        repeat (PHASE_ITEMS) random_request();
        drain_replies(0, 0);
        repeat (PHASE_ITEMS) random_request();
        drain_replies(0, 0);

        // a free is the slowest request; give it room to misbehave
        repeat (100) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && replies_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
